FILE: design/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the TLV parameter store.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int MEM_BYTES_DEF = 1024;

    localparam logic [7:0] FREE_TAG = 8'hFF;
    localparam logic [3:0] MAX_BUF  = 4'd8;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [1:0]
    {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_ERASE = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    typedef struct packed
    {
        act_t        action;
        logic [7:0]  tag;
        logic [7:0]  record_len;
        logic [7:0]  offset;
        logic [3:0]  buf_len;
        logic [63:0] write_data;
    } tps_req_t;

    typedef struct packed
    {
        logic [3:0]  count;
        logic [63:0] read_data;
    } tps_res_t;

endpackage

FILE: design/tps_core.sv
// ----------------------------------------------------------------------------
// tps_core
// Byte store and sequencer: record walk, create, byte transfer, erase sweep.
// ----------------------------------------------------------------------------
module tps_core
#(
    parameter int MEM_BYTES = tps_pkg::MEM_BYTES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tps_pkg::tps_req_t req,
    input  logic            out_free,
    output logic            done,
    output tps_pkg::tps_res_t res
);
    import tps_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(MEM_BYTES + 264);
    localparam logic [PW-1:0] MEM_P     = PW'(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST  = AW'(MEM_BYTES - 1);

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_TAG,
        ST_LEN,
        ST_EVAL,
        ST_CR_TAG,
        ST_CR_LEN,
        ST_SETUP,
        ST_RD_ISSUE,
        ST_RD_CAPT,
        ST_WR,
        ST_DONE
    } state_t;

    logic [7:0] mem [MEM_BYTES];

    state_t      state_reg;
    logic        pend_reg;
    logic [AW-1:0] clr_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] at_reg;
    logic [PW-1:0] addr_reg;
    logic [7:0]  tag_seen_reg;
    logic [7:0]  len_reg;
    logic [3:0]  idx_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] rd_reg;
    logic [63:0] data_reg;
    act_t        act_reg;
    logic [7:0]  key_reg;
    logic [7:0]  rlen_reg;
    logic [7:0]  off_reg;
    logic [3:0]  n_reg;
    logic [7:0]  rdata_reg;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    logic [PW-1:0] hdr_end;
    logic [PW-1:0] room;
    logic [7:0]    len_clip;
    logic [3:0]    n_sat;
    logic          addr_ok;

    function automatic logic [3:0] clip_count(input logic [7:0] off, input logic [7:0] len,
                                              input logic [3:0] n);
        logic [8:0] sum;
        logic [8:0] rest;
        begin
            sum  = {1'b0, off} + {5'd0, n};
            rest = {1'b0, len} - {1'b0, off};
            if (off > len)
                clip_count = 4'd0;
            else if (sum > {1'b0, len})
                clip_count = rest[3:0];
            else
                clip_count = n;
        end
    endfunction

    assign hdr_end  = pos_reg + PW'(2) + PW'(rdata_reg);
    assign room     = MEM_P - pos_reg - PW'(2);
    assign len_clip = (hdr_end > MEM_P) ? room[7:0] : rdata_reg;
    assign n_sat    = (req.buf_len > MAX_BUF) ? MAX_BUF : req.buf_len;
    assign addr_ok  = addr_reg < MEM_P;

    assign req_ready = (state_reg == ST_IDLE);
    assign done      = (state_reg == ST_DONE) && out_free;
    assign res.count     = cnt_reg;
    assign res.read_data = rd_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = addr_reg[AW-1:0];
        mem_wdata = data_reg[7:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = FREE_TAG;
            end
            ST_TAG:    mem_addr = pos_reg[AW-1:0];
            ST_LEN:    mem_addr = AW'(pos_reg + PW'(1));
            ST_CR_TAG:
            begin
                mem_we    = 1'b1;
                mem_addr  = at_reg[AW-1:0];
                mem_wdata = key_reg;
            end
            ST_CR_LEN:
            begin
                mem_we    = 1'b1;
                mem_addr  = AW'(at_reg + PW'(1));
                mem_wdata = rlen_reg;
            end
            ST_WR:     mem_we = (idx_reg != cnt_reg) && addr_ok;
            default:   mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        clr_reg   <= '0;
                        state_reg <= pend_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        pend_reg <= 1'b1;
                        act_reg  <= req.action;
                        key_reg  <= req.tag;
                        rlen_reg <= req.record_len;
                        off_reg  <= req.offset;
                        n_reg    <= n_sat;
                        data_reg <= req.write_data;
                        pos_reg  <= '0;
                        cnt_reg  <= '0;
                        rd_reg   <= '0;
                        idx_reg  <= '0;
                        priority if (req.action == ACT_ERASE)
                            state_reg <= ST_CLEAR;
                        else if ((req.action == ACT_READ || req.action == ACT_WRITE)
                                 && req.tag != FREE_TAG)
                            state_reg <= ST_TAG;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_TAG:
                begin
                    if (pos_reg + PW'(1) < MEM_P)
                        state_reg <= ST_LEN;
                    else
                        state_reg <= ST_DONE;
                end
                ST_LEN:
                begin
                    tag_seen_reg <= rdata_reg;
                    state_reg    <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    priority if (tag_seen_reg == key_reg)
                    begin
                        at_reg    <= pos_reg;
                        len_reg   <= len_clip;
                        state_reg <= ST_SETUP;
                    end
                    else if (tag_seen_reg == FREE_TAG)
                    begin
                        at_reg <= pos_reg;
                        if (act_reg == ACT_WRITE && rlen_reg == {4'd0, n_reg}
                            && len_clip > rlen_reg)
                            state_reg <= ST_CR_TAG;
                        else
                            state_reg <= ST_DONE;
                    end
                    else
                    begin
                        pos_reg   <= hdr_end;
                        state_reg <= ST_TAG;
                    end
                end
                ST_CR_TAG: state_reg <= ST_CR_LEN;
                ST_CR_LEN:
                begin
                    len_reg   <= rlen_reg;
                    state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    cnt_reg   <= clip_count(off_reg, len_reg, n_reg);
                    addr_reg  <= at_reg + PW'(2) + PW'(off_reg);
                    idx_reg   <= '0;
                    state_reg <= (act_reg == ACT_READ) ? ST_RD_ISSUE : ST_WR;
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= (idx_reg == cnt_reg) ? ST_DONE : ST_RD_CAPT;
                end
                ST_RD_CAPT:
                begin
                    if (addr_ok)
                        rd_reg[idx_reg[2:0]*8 +: 8] <= rdata_reg;
                    idx_reg   <= idx_reg + 4'd1;
                    addr_reg  <= addr_reg + PW'(1);
                    state_reg <= ST_RD_ISSUE;
                end
                ST_WR:
                begin
                    if (idx_reg == cnt_reg)
                        state_reg <= ST_DONE;
                    else
                    begin
                        data_reg <= data_reg >> 8;
                        idx_reg  <= idx_reg + 4'd1;
                        addr_reg <= addr_reg + PW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_free)
        else $error("result issued with output slot full");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res.count <= MAX_BUF)
        else $error("count above buffer size");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && act_reg != ACT_READ |-> res.read_data == 64'd0)
        else $error("read data on non-read action");

    a_hdr_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEN |-> pos_reg + PW'(1) < MEM_P)
        else $error("header read past end of store");

endmodule

FILE: design/tlv_parameter_store.sv
// ----------------------------------------------------------------------------
// tlv_parameter_store
// Tag-length-value record store with read, write/create and erase words.
//
//   port group   dir  tdata / tuser
//   s_*          in   tdata: tag, record_len, offset, buf_len, write_data
//                     tuser: action
//   m_*          out  tdata: count, read_data
//
// A word walks the record headers one by one, then reads or writes its bytes
// one at a time through the single memory port; erase sweeps every byte of
// the store. After reset a sweep fills the store with 0xFF; s_tready stays
// low until it ends. A waiting result does not block acceptance of the next
// word; that word's result is held until the output slot is free.
// ----------------------------------------------------------------------------
module tlv_parameter_store
#(
    parameter int MEM_BYTES = tps_pkg::MEM_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tag[7:0], record_len[15:8], offset[23:16], buf_len[27:24],
    // write_data[91:28], zero[95:92]
    input  logic [tps_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // count[3:0], read_data[67:4], zero[71:68]
    output logic [tps_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tps_pkg::*;

    tps_req_t req;
    tps_res_t res;
    tps_res_t out_reg;
    logic     out_valid_reg;
    logic     out_free;
    logic     done;

    assign req.action     = act_t'(s_tuser);
    assign req.tag        = s_tdata[7:0];
    assign req.record_len = s_tdata[15:8];
    assign req.offset     = s_tdata[23:16];
    assign req.buf_len    = s_tdata[27:24];
    assign req.write_data = s_tdata[91:28];

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.read_data, out_reg.count};

    tps_core
    #(
        .MEM_BYTES (MEM_BYTES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .out_free  (out_free),
        .done      (done),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= res;
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TLV parameter store. A directed pass covers
// lookup misses, record creation, clipping, oversized requests, the free tag,
// the unused action and erase. Random phases then fill the store with records
// and mix reads and writes over it. Every result word is checked against a
// typed expectation or a byte-level image of the store kept by the bench. Random gaps and stalls are
// applied on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import tps_pkg::*;

    localparam int MEM   = MEM_BYTES_DEF;
    localparam int LIMIT = 3_000_000;
    localparam int DRAIN = 1200;

    typedef struct
    {
        tps_req_t req;
        bit       known;
        tps_res_t res;
    } dir_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = 2'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [7:0] store_image [0:MEM-1];
    tps_res_t   pending_q [$];
    dir_row_t   dir_rows [$];
    int         mismatches = 0;
    int         cycles     = 0;
    int         stall_left = 0;
    bit         calm       = 1'b0;

    tlv_parameter_store u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int a = 0; a < MEM; a++)
        begin
            store_image[a] = FREE_TAG;
        end
    end

    function automatic bit find_record(input logic [7:0] key, output int at, output int len);
        int pos;
        pos = 0;
        at  = 0;
        len = 0;
        while (pos + 1 < MEM)
        begin
            len = int'(store_image[pos + 1]);
            if (store_image[pos] == key)
            begin
                if (pos + 2 + len > MEM)
                    len = MEM - pos - 2;
                at = pos;
                return 1'b1;
            end
            if (store_image[pos] == FREE_TAG)
                return 1'b0;
            pos += 2 + len;
        end
        return 1'b0;
    endfunction

    function automatic int clip_count(input int off, input int len, input int n);
        if (off > len)
            return 0;
        if (off + n > len)
            return len - off;
        return n;
    endfunction

    // applies one word to the store image and returns the result it should give
    function automatic tps_res_t predict_word(input tps_req_t w);
        int       n;
        int       at;
        int       len;
        int       cnt;
        int       a;
        int       i;
        bit       hit;
        tps_res_t r;
        r   = '0;
        cnt = 0;
        n   = (w.buf_len > MAX_BUF) ? int'(MAX_BUF) : int'(w.buf_len);
        if (w.action == ACT_ERASE)
        begin
            for (a = 0; a < MEM; a++)
                store_image[a] = FREE_TAG;
        end
        else if (w.tag != FREE_TAG && (w.action == ACT_READ || w.action == ACT_WRITE))
        begin
            hit = find_record(w.tag, at, len);
            // absent record: create at the free mark when the write covers the value
            if (w.action == ACT_WRITE && !hit && int'(w.record_len) == n)
            begin
                if (find_record(FREE_TAG, at, len) && len > int'(w.record_len))
                begin
                    store_image[at]     = w.tag;
                    store_image[at + 1] = w.record_len;
                    len = int'(w.record_len);
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                cnt = clip_count(int'(w.offset), len, n);
                for (i = 0; i < cnt; i++)
                begin
                    a = at + 2 + int'(w.offset) + i;
                    if (a < MEM)
                    begin
                        if (w.action == ACT_READ)
                            r.read_data[8*i +: 8] = store_image[a];
                        else
                            store_image[a] = w.write_data[8*i +: 8];
                    end
                end
            end
        end
        r.count = cnt[3:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input act_t act, input logic [7:0] tag, input logic [7:0] rlen,
                           input logic [7:0] off, input logic [3:0] n, input logic [63:0] data,
                           input bit known, input logic [3:0] cnt, input logic [63:0] rd);
        dir_row_t row;
        row.req.action     = act;
        row.req.tag        = tag;
        row.req.record_len = rlen;
        row.req.offset     = off;
        row.req.buf_len    = n;
        row.req.write_data = data;
        row.known          = known;
        row.res.count      = cnt;
        row.res.read_data  = rd;
        dir_rows.push_back(row);
    endtask

    task automatic send_word(input tps_req_t w, input bit known, input tps_res_t typed);
        int       gap;
        tps_res_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, w.write_data, w.buf_len, w.offset, w.record_len, w.tag};
        s_tuser  <= w.action;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_word(w);
        pending_q.push_back(known ? typed : pred);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tps_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with no expectation: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (m_tdata[3:0] !== want.count)
                begin
                    $error("count mismatch: expected %0d, got %0d", want.count, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[67:4] !== want.read_data)
                begin
                    $error("read_data mismatch: expected %h, got %h",
                           want.read_data, m_tdata[67:4]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        tps_req_t w;
        tps_res_t none;
        int       nsat;
        int       ph;
        int       t;
        int       r;
        int       sent;
        int       pool_hi;
        int       base;
        none = '0;
        sent = 0;

        add_row(ACT_READ,  8'd5,   8'd0,   8'd0,   4'd8,  64'h0,                  1, 4'd0, 64'h0);
        add_row(ACT_WRITE, 8'd5,   8'd8,   8'd0,   4'd8,  64'h0123_4567_89AB_CDEF, 1, 4'd8, 64'h0);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd0,   4'd8,  64'h0,
                1, 4'd8, 64'h0123_4567_89AB_CDEF);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd3,   4'd8,  64'h0,                  0, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd8,   4'd4,  64'h0,                  0, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd255, 4'd8,  64'h0,                  1, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd0,   4'd15, 64'h0,
                1, 4'd8, 64'h0123_4567_89AB_CDEF);
        add_row(ACT_WRITE, FREE_TAG, 8'd8, 8'd0,   4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1, 4'd0, 64'h0);
        add_row(ACT_READ,  FREE_TAG, 8'd0, 8'd0,   4'd8,  64'h0,                  1, 4'd0, 64'h0);
        add_row(ACT_NONE,  8'd5,   8'd8,   8'd0,   4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1, 4'd0, 64'h0);
        add_row(ACT_WRITE, 8'd7,   8'd4,   8'd0,   4'd3,  64'h0000_0000_00AB_CDEF, 1, 4'd0, 64'h0);
        add_row(ACT_WRITE, 8'd7,   8'd8,   8'd0,   4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1, 4'd8, 64'h0);
        add_row(ACT_READ,  8'd7,   8'd0,   8'd0,   4'd8,  64'h0,
                1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        add_row(ACT_WRITE, 8'd0,   8'd0,   8'd0,   4'd0,  64'h0,                  0, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd0,   8'd0,   8'd0,   4'd8,  64'h0,                  1, 4'd0, 64'h0);
        add_row(ACT_WRITE, 8'd254, 8'd1,   8'd255, 4'd1,  64'h0000_0000_0000_00AA, 0, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd254, 8'd0,   8'd0,   4'd8,  64'h0,                  0, 4'd0, 64'h0);
        add_row(ACT_WRITE, 8'd5,   8'd0,   8'd2,   4'd3,  64'h0000_0000_0055_6677, 0, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd0,   4'd8,  64'h0,                  0, 4'd0, 64'h0);
        add_row(ACT_WRITE, 8'd9,   8'd255, 8'd0,   4'd8,  64'h1234_5678_9ABC_DEF0, 1, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd7,   8'd0,   8'd6,   4'd8,  64'h0,                  0, 4'd0, 64'h0);
        add_row(ACT_ERASE, 8'd0,   8'd0,   8'd0,   4'd0,  64'h0,                  1, 4'd0, 64'h0);
        add_row(ACT_READ,  8'd5,   8'd0,   8'd0,   4'd8,  64'h0,                  1, 4'd0, 64'h0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].req, dir_rows[k].known, dir_rows[k].res);

        for (ph = 0; ph < 4; ph++)
        begin
            w = '0;
            w.action = ACT_ERASE;
            send_word(w, 1'b1, none);

            // fill the store with a run of 130 record creations; later ones fail once it runs out of room
            if (ph == 1 || ph == 3)
            begin
                base = (ph == 1) ? 0 : 120;
                for (t = 0; t < 130; t++)
                begin
                    nsat = $urandom_range(4, 8);
                    w.action     = ACT_WRITE;
                    w.tag        = 8'(base + t);
                    w.record_len = 8'(nsat);
                    w.offset     = 8'($urandom_range(0, 2));
                    w.buf_len    = (nsat == 8 && $urandom_range(0, 1) == 1) ?
                                   4'($urandom_range(9, 15)) : 4'(nsat);
                    w.write_data = {$urandom, $urandom};
                    send_word(w, 1'b0, none);
                    sent++;
                    if (sent % 32 == 0)
                        calm = ($urandom_range(0, 3) == 0);
                end
            end

            case (ph)
                0:       pool_hi = 15;
                1:       pool_hi = 129;
                2:       pool_hi = 31;
                default: pool_hi = 254;
            endcase
            for (t = 0; t < 65; t++)
            begin
                r = $urandom_range(0, 99);
                w.action     = (r < 3) ? ACT_NONE : (r < 48) ? ACT_READ : ACT_WRITE;
                w.tag        = ($urandom_range(0, 24) == 0) ? FREE_TAG :
                               8'($urandom_range(0, pool_hi));
                w.buf_len    = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15)) :
                               4'($urandom_range(0, 8));
                nsat         = (w.buf_len > MAX_BUF) ? int'(MAX_BUF) : int'(w.buf_len);
                w.record_len = ($urandom_range(0, 9) < 6) ? 8'(nsat) : 8'($urandom_range(0, 255));
                w.offset     = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                               8'($urandom_range(0, 9));
                w.write_data = {$urandom, $urandom};
                send_word(w, 1'b0, none);
                sent++;
                if (sent % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
